// ===== rtl/rfs_pkg.sv =====
// Shared types, widths, constants and example tables for the range steering block.
package rfs_pkg;

  // Fixed-point format and derived constants.
  localparam int FRAC_BITS = 12;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int HALF      = ONE / 2;

  // Field widths.
  localparam int RW  = 16;             // range reading and smoothed range
  localparam int CW  = 17;             // smoothed change, signed
  localparam int MW  = 13;             // mix factor
  localparam int PW  = RW + MW + 3;    // averaging product sum
  localparam int SQA = 2 * RW + 3;     // sum of three squared differences
  localparam int RTW = 2 * FRAC_BITS;  // square root remainder
  localparam int WW  = FRAC_BITS + 1;  // example weight
  localparam int VW  = FRAC_BITS + 2;  // example output value, signed
  localparam int SW  = 2 * FRAC_BITS + 5;  // weighted sums, signed
  localparam int TW  = FRAC_BITS + 5;  // total weight
  localparam int QW  = FRAC_BITS + 1;  // quotient
  localparam int STEERW = FRAC_BITS + 2;
  localparam int NEX = 9;
  localparam int EXW = $clog2(NEX);
  localparam int STW = $clog2(FRAC_BITS + 1);
  localparam int CIW = 2;

  // Reset values.
  localparam logic [RW-1:0] MIN_RANGE_RST = RW'(410);
  localparam logic [RW-1:0] MAX_RANGE_RST = RW'(8192);
  localparam logic [MW-1:0] MIX_RST       = MW'(1024);
  localparam logic [RW-1:0] SRANGE_RST    = RW'(16384);
  localparam int            SAT_MAX       = (1 << RW) - 1;

  // Configuration register indexes.
  localparam logic [CIW-1:0] CFG_MIN_RANGE = CIW'(0);
  localparam logic [CIW-1:0] CFG_MAX_RANGE = CIW'(1);
  localparam logic [CIW-1:0] CFG_MIX       = CIW'(2);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic           load;
    logic           avg_en;
    logic [1:0]     chan;
    logic           chg;
    logic           sq_en;
    logic [1:0]     coord;
    logic           sq_last;
    logic [EXW-1:0] ex;
    logic           root_en;
    logic           acc_en;
    logic           div_init;
    logic           div_en;
    logic           out_load;
  } rfs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sq_big;
  } rfs_stat_t;

  // Example coordinate in quarters of max_range.
  function automatic logic [2:0] ex_pos(input logic [EXW-1:0] k, input logic [1:0] i);
    logic [8:0] row;
    case (k)
      EXW'(0): row = {3'd4, 3'd4, 3'd4};
      EXW'(1): row = {3'd4, 3'd4, 3'd2};
      EXW'(2): row = {3'd2, 3'd4, 3'd4};
      EXW'(3): row = {3'd0, 3'd4, 3'd4};
      EXW'(4): row = {3'd4, 3'd4, 3'd0};
      EXW'(5): row = {3'd2, 3'd0, 3'd4};
      EXW'(6): row = {3'd4, 3'd0, 3'd2};
      EXW'(7): row = {3'd3, 3'd2, 3'd4};
      EXW'(8): row = {3'd4, 3'd2, 3'd3};
      default: row = 9'd0;
    endcase
    case (i)
      2'd0:    return row[8:6];
      2'd1:    return row[5:3];
      default: return row[2:0];
    endcase
  endfunction

  // Fraction in twentieths scaled to the fixed-point format, rounded by magnitude.
  function automatic logic signed [VW-1:0] twentieths(input int v);
    int mag;
    int r;
    mag = (v < 0) ? -v : v;
    r   = (mag * ONE + 10) / 20;
    return VW'((v < 0) ? -r : r);
  endfunction

  // Example output: steering, throttle and confidence.
  function automatic logic signed [VW-1:0] ex_val(input logic [EXW-1:0] k, input logic [1:0] j);
    logic signed [VW-1:0] s;
    logic signed [VW-1:0] t;
    logic signed [VW-1:0] c;
    case (k)
      EXW'(0): begin s = twentieths(0);   t = twentieths(20); c = twentieths(2);  end
      EXW'(1): begin s = twentieths(-15); t = twentieths(10); c = twentieths(8);  end
      EXW'(2): begin s = twentieths(15);  t = twentieths(10); c = twentieths(8);  end
      EXW'(3): begin s = twentieths(20);  t = twentieths(10); c = twentieths(10); end
      EXW'(4): begin s = twentieths(-20); t = twentieths(10); c = twentieths(10); end
      EXW'(5): begin s = twentieths(20);  t = twentieths(5);  c = twentieths(14); end
      EXW'(6): begin s = twentieths(-20); t = twentieths(5);  c = twentieths(14); end
      EXW'(7): begin s = twentieths(10);  t = twentieths(5);  c = twentieths(10); end
      EXW'(8): begin s = twentieths(-10); t = twentieths(5);  c = twentieths(10); end
      default: begin s = '0;              t = '0;             c = '0;             end
    endcase
    case (j)
      2'd0:    return s;
      2'd1:    return t;
      default: return c;
    endcase
  endfunction

endpackage

// ===== rtl/rfs_ctrl.sv =====
// Sequencing state machine for the range steering block.
module rfs_ctrl
  import rfs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  rfs_stat_t stat,
  output rfs_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_AVG, ST_SQ, ST_ROOT, ST_ACC, ST_DIVI, ST_DIV, ST_DONE
  } state_t;

  localparam int AVG_STEPS = 6;

  state_t           state_r, state_nxt;
  logic [STW-1:0]   step_r, step_nxt;
  logic [EXW-1:0]   ex_r, ex_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Next-state and command decode.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    ex_nxt    = ex_r;
    cmd       = '0;
    cmd.chan  = step_r[2:1];
    cmd.chg   = step_r[0];
    cmd.coord = step_r[1:0];
    cmd.ex    = ex_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          step_nxt  = '0;
          state_nxt = ST_AVG;
        end
      end
      ST_AVG: begin
        cmd.avg_en = 1'b1;
        if (step_r == STW'(AVG_STEPS - 1)) begin
          step_nxt  = '0;
          ex_nxt    = '0;
          state_nxt = ST_SQ;
        end else begin
          step_nxt = step_r + STW'(1);
        end
      end
      ST_SQ: begin
        cmd.sq_en = 1'b1;
        if (step_r == STW'(2)) begin
          cmd.sq_last = 1'b1;
          step_nxt    = '0;
          state_nxt   = stat.sq_big ? ST_ACC : ST_ROOT;
        end else begin
          step_nxt = step_r + STW'(1);
        end
      end
      ST_ROOT: begin
        cmd.root_en = 1'b1;
        if (step_r == STW'(FRAC_BITS - 1)) begin
          step_nxt  = '0;
          state_nxt = ST_ACC;
        end else begin
          step_nxt = step_r + STW'(1);
        end
      end
      ST_ACC: begin
        cmd.acc_en = 1'b1;
        if (ex_r == EXW'(NEX - 1)) begin
          state_nxt = ST_DIVI;
        end else begin
          ex_nxt    = ex_r + EXW'(1);
          state_nxt = ST_SQ;
        end
      end
      ST_DIVI: begin
        cmd.div_init = 1'b1;
        step_nxt     = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_en = 1'b1;
        if (step_r == STW'(QW - 1)) begin
          state_nxt = ST_DONE;
        end else begin
          step_nxt = step_r + STW'(1);
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output register occupancy.
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      ex_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      ex_r        <= ex_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== rtl/rfs_dp.sv =====
// Datapath: smoothing, example distances, weighting and division.
module rfs_dp
  import rfs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CIW-1:0]           cfg_index,
  input  logic [RW-1:0]            cfg_data,
  input  logic [RW-1:0]            in_range_left,
  input  logic [RW-1:0]            in_range_centre,
  input  logic [RW-1:0]            in_range_right,
  input  rfs_cmd_t                 cmd,
  output rfs_stat_t                stat,
  output logic signed [STEERW-1:0] out_steer_cmd,
  output logic [QW-1:0]            out_throttle_cmd,
  output logic [QW-1:0]            out_confidence_out,
  output logic [RW-1:0]            out_avg_left,
  output logic [RW-1:0]            out_avg_centre,
  output logic [RW-1:0]            out_avg_right,
  output logic signed [CW-1:0]     out_rate_left,
  output logic signed [CW-1:0]     out_rate_centre,
  output logic signed [CW-1:0]     out_rate_right
);

  // Configuration registers.
  logic [RW-1:0] min_r, max_r;
  logic [MW-1:0] mix_r;

  // Item state.
  logic [RW-1:0]        in_r     [3];
  logic [RW-1:0]        prev_r   [3];
  logic [RW-1:0]        srange_r [3];
  logic signed [CW-1:0] schange_r[3];

  // Distance and root state.
  logic [SQA-1:0] sq_r;
  logic [RTW-1:0] rem_r;
  logic [RTW:0]   res_r;
  logic [RTW:0]   bit_r;
  logic           wzero_r;

  // Weighted sums and division lanes.
  logic signed [SW-1:0] sum_r[3];
  logic [TW-1:0]        total_r;
  logic [SW-1:0]        num_r[3];
  logic [QW-1:0]        q_r[3];
  logic                 neg_r[3];
  logic [SW-1:0]        den_r;
  logic                 zero_r;

  // Output registers.
  logic signed [STEERW-1:0] steer_r;
  logic [QW-1:0]            thr_r, conf_r;
  logic [RW-1:0]            oavg_r[3];
  logic signed [CW-1:0]     orate_r[3];

  // Exponential averaging of one range or one change.
  logic [MW-1:0]          m, rm;
  logic signed [MW:0]     m_s, rm_s;
  logic signed [RW+1:0]   opx, opo;
  logic signed [PW-1:0]   mix_sum, rnd;
  logic [RW-1:0]          avg_sat;
  logic signed [CW-1:0]   chg_sat;

  always_comb begin
    m    = (mix_r > MW'(ONE)) ? MW'(ONE) : mix_r;
    rm   = MW'(ONE) - m;
    m_s  = $signed({1'b0, m});
    rm_s = $signed({1'b0, rm});
    if (cmd.chg) begin
      opx = $signed({2'b00, in_r[cmd.chan]}) - $signed({2'b00, prev_r[cmd.chan]});
      opo = (RW + 2)'(schange_r[cmd.chan]);
    end else begin
      opx = $signed({2'b00, in_r[cmd.chan]});
      opo = $signed({2'b00, srange_r[cmd.chan]});
    end
    mix_sum = PW'(m_s) * PW'(opx) + PW'(rm_s) * PW'(opo);
    rnd     = (mix_sum + PW'(HALF)) >>> FRAC_BITS;
    if (rnd < 0) begin
      avg_sat = '0;
    end else if (rnd > PW'(SAT_MAX)) begin
      avg_sat = RW'(SAT_MAX);
    end else begin
      avg_sat = rnd[RW-1:0];
    end
    if (rnd > PW'(SAT_MAX)) begin
      chg_sat = CW'(SAT_MAX);
    end else if (rnd < -PW'(SAT_MAX)) begin
      chg_sat = -CW'(SAT_MAX);
    end else begin
      chg_sat = rnd[CW-1:0];
    end
  end

  // Squared distance along one coordinate to one example.
  logic [RW-1:0]        lo_c, pt;
  logic [2:0]           quarter;
  logic [RW+1:0]        three_max;
  logic [RW+1:0]        ex_c;
  logic signed [RW+1:0] diff;
  logic signed [2*RW+3:0] sqd;
  logic [SQA-1:0]       sq_nxt;

  always_comb begin
    lo_c      = (srange_r[cmd.coord] < min_r) ? min_r : srange_r[cmd.coord];
    pt        = (lo_c > max_r) ? max_r : lo_c;
    quarter   = ex_pos(cmd.ex, cmd.coord);
    three_max = {2'b00, max_r} + {1'b0, max_r, 1'b0};
    case (quarter)
      3'd4:    ex_c = {2'b00, max_r};
      3'd3:    ex_c = (three_max + (RW + 2)'(2)) >> 2;
      3'd2:    ex_c = ({2'b00, max_r} + (RW + 2)'(1)) >> 1;
      default: ex_c = '0;
    endcase
    diff   = $signed({2'b00, pt}) - $signed(ex_c);
    sqd    = diff * diff;
    sq_nxt = ((cmd.coord == 2'd0) ? '0 : sq_r) + SQA'(unsigned'(sqd));
    stat.sq_big = |sq_nxt[SQA-1:RTW];
  end

  // One restoring square-root step.
  logic [RTW:0] trial;
  logic         take;
  always_comb begin
    trial = res_r + bit_r;
    take  = ({1'b0, rem_r} >= trial);
  end

  // Weight and weighted contributions of one example.
  logic [WW-1:0]           w;
  logic signed [2*VW-1:0]  prod[3];
  always_comb begin
    w = wzero_r ? '0 : (WW'(ONE) - {1'b0, res_r[FRAC_BITS-1:0]});
    for (int j = 0; j < 3; j++) begin
      prod[j] = $signed({1'b0, w}) * ex_val(cmd.ex, 2'(j));
    end
  end

  // Division lane steps.
  logic [SW-1:0] mag[3];
  logic          ge[3];
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      mag[j] = (sum_r[j] < 0) ? SW'(-sum_r[j]) : SW'(sum_r[j]);
      ge[j]  = (num_r[j] >= den_r);
    end
  end

  // Configuration and smoothing state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= MIN_RANGE_RST;
      max_r <= MAX_RANGE_RST;
      mix_r <= MIX_RST;
      for (int i = 0; i < 3; i++) begin
        srange_r[i]  <= SRANGE_RST;
        schange_r[i] <= '0;
        prev_r[i]    <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MIN_RANGE: min_r <= cfg_data;
          CFG_MAX_RANGE: max_r <= cfg_data;
          CFG_MIX:       mix_r <= cfg_data[MW-1:0];
          default: ;
        endcase
      end
      if (cmd.avg_en) begin
        if (cmd.chg) begin
          schange_r[cmd.chan] <= chg_sat;
          prev_r[cmd.chan]    <= in_r[cmd.chan];
        end else begin
          srange_r[cmd.chan] <= avg_sat;
        end
      end
    end
  end

  // Working registers of one transaction.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r[0] <= in_range_left;
      in_r[1] <= in_range_centre;
      in_r[2] <= in_range_right;
      total_r <= '0;
      for (int j = 0; j < 3; j++) begin
        sum_r[j] <= '0;
      end
    end
    if (cmd.sq_en) begin
      sq_r <= sq_nxt;
      if (cmd.sq_last) begin
        rem_r   <= sq_nxt[RTW-1:0];
        res_r   <= '0;
        bit_r   <= (RTW + 1)'(1) << (RTW - 2);
        wzero_r <= stat.sq_big;
      end
    end
    if (cmd.root_en) begin
      if (take) begin
        rem_r <= RTW'({1'b0, rem_r} - trial);
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (cmd.acc_en) begin
      total_r <= total_r + TW'(w);
      for (int j = 0; j < 3; j++) begin
        sum_r[j] <= sum_r[j] + SW'(prod[j]);
      end
    end
    if (cmd.div_init) begin
      den_r  <= SW'(total_r) << (QW - 1);
      zero_r <= (total_r == '0);
      for (int j = 0; j < 3; j++) begin
        num_r[j] <= mag[j] + SW'(total_r >> 1);
        neg_r[j] <= (sum_r[j] < 0);
        q_r[j]   <= '0;
      end
    end
    if (cmd.div_en) begin
      den_r <= den_r >> 1;
      for (int j = 0; j < 3; j++) begin
        if (ge[j]) begin
          num_r[j] <= num_r[j] - den_r;
        end
        q_r[j] <= {q_r[j][QW-2:0], ge[j]};
      end
    end
    if (cmd.out_load) begin
      if (zero_r) begin
        steer_r <= '0;
        thr_r   <= '0;
        conf_r  <= '0;
      end else begin
        steer_r <= neg_r[0] ? -$signed({1'b0, q_r[0]}) : $signed({1'b0, q_r[0]});
        thr_r   <= q_r[1];
        conf_r  <= q_r[2];
      end
      for (int i = 0; i < 3; i++) begin
        oavg_r[i]  <= srange_r[i];
        orate_r[i] <= schange_r[i];
      end
    end
  end

  assign out_steer_cmd      = steer_r;
  assign out_throttle_cmd   = thr_r;
  assign out_confidence_out = conf_r;
  assign out_avg_left       = oavg_r[0];
  assign out_avg_centre     = oavg_r[1];
  assign out_avg_right      = oavg_r[2];
  assign out_rate_left      = orate_r[0];
  assign out_rate_centre    = orate_r[1];
  assign out_rate_right     = orate_r[2];

endmodule

// ===== rtl/range_fuzzy_steering.sv =====
// Each transaction is taken through smoothing and the per-example distance loop
// (3 square steps, a 12-step square root skipped for far examples, 1 step).
// Inputs: one transaction at a time; the next input is taken while a result waits.
// Division: three 13-step lanes run in parallel after the ninth example.
// Reset: synchronous active-low rst_n restores the configuration registers and controller
// state, smoothed ranges to 16384, changes and previous ranges to zero; no result is pending after reset.
module range_fuzzy_steering
  import rfs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CIW-1:0]           cfg_index,
  input  logic [RW-1:0]            cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [RW-1:0]            in_range_left,
  input  logic [RW-1:0]            in_range_centre,
  input  logic [RW-1:0]            in_range_right,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [STEERW-1:0] out_steer_cmd,
  output logic [QW-1:0]            out_throttle_cmd,
  output logic [QW-1:0]            out_confidence_out,
  output logic [RW-1:0]            out_avg_left,
  output logic [RW-1:0]            out_avg_centre,
  output logic [RW-1:0]            out_avg_right,
  output logic signed [CW-1:0]     out_rate_left,
  output logic signed [CW-1:0]     out_rate_centre,
  output logic signed [CW-1:0]     out_rate_right
);

  rfs_cmd_t  cmd;
  rfs_stat_t stat;

  // Sequencer.
  rfs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Arithmetic and storage.
  rfs_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_range_left      (in_range_left),
    .in_range_centre    (in_range_centre),
    .in_range_right     (in_range_right),
    .cmd                (cmd),
    .stat               (stat),
    .out_steer_cmd      (out_steer_cmd),
    .out_throttle_cmd   (out_throttle_cmd),
    .out_confidence_out (out_confidence_out),
    .out_avg_left       (out_avg_left),
    .out_avg_centre     (out_avg_centre),
    .out_avg_right      (out_avg_right),
    .out_rate_left      (out_rate_left),
    .out_rate_centre    (out_rate_centre),
    .out_rate_right     (out_rate_right)
  );

  // An accepted transaction keeps the input side stalled while it is worked on.
  a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> in_stall)
    else $error("input not stalled after accepting a transaction");

  // A result is only written into a free or draining output register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid && out_stall))
    else $error("pending result overwritten");

  // A written result is presented on the next cycle.
  a_valid_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid)
    else $error("result not presented after load");

  // The controller issues at most one datapath operation per cycle.
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.avg_en, cmd.sq_en, cmd.root_en, cmd.acc_en,
              cmd.div_init, cmd.div_en, cmd.out_load}))
    else $error("overlapping datapath commands");

endmodule

// ===== sim/tb_range_fuzzy_steering.sv =====
// Self-checking testbench for the range steering block: drives range readings, predicts results.
module tb_range_fuzzy_steering
  import rfs_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CIW-1:0] CFG_UNUSED = CIW'(3);
  localparam int SETTLE_CYCLES = 250;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int HOLD_CYCLES = 700;
  localparam int NUM_PHASES = 6;

  // Example points in quarters of max_range and their outputs in twentieths.
  localparam int EX_QUARTER[NEX][3] = '{
    '{4, 4, 4}, '{4, 4, 2}, '{2, 4, 4}, '{0, 4, 4}, '{4, 4, 0},
    '{2, 0, 4}, '{4, 0, 2}, '{3, 2, 4}, '{4, 2, 3}};
  localparam int EX_TWENTIETH[NEX][3] = '{
    '{0, 20, 2}, '{-15, 10, 8}, '{15, 10, 8}, '{20, 10, 10}, '{-20, 10, 10},
    '{20, 5, 14}, '{-20, 5, 14}, '{10, 5, 10}, '{-10, 5, 10}};

  typedef struct packed {
    logic [RW-1:0] left;
    logic [RW-1:0] centre;
    logic [RW-1:0] right;
  } ranges_t;

  typedef struct packed {
    logic signed [STEERW-1:0] steer;
    logic [QW-1:0]            throttle;
    logic [QW-1:0]            confidence;
    logic [RW-1:0]            avg_l;
    logic [RW-1:0]            avg_c;
    logic [RW-1:0]            avg_r;
    logic signed [CW-1:0]     rate_l;
    logic signed [CW-1:0]     rate_c;
    logic signed [CW-1:0]     rate_r;
  } steering_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CIW-1:0] cfg_index = '0;
  logic [RW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [RW-1:0] in_range_left = '0;
  logic [RW-1:0] in_range_centre = '0;
  logic [RW-1:0] in_range_right = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  steering_t dut_result;

  ranges_t pending_ranges[$];
  steering_t expected_steering[$];

  // Shadow registers and smoothing state of the predictor.
  longint shadow_min, shadow_max, shadow_mix;
  longint avg_state[3];
  longint rate_state[3];
  longint last_reading[3];

  int cyc = 0;
  int stall_wait = 0;
  int mismatches = 0;
  int results_seen = 0;
  int readings_sent = 0;
  int zero_weight_seen = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  range_fuzzy_steering u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_range_left(in_range_left), .in_range_centre(in_range_centre),
    .in_range_right(in_range_right),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_steer_cmd(dut_result.steer), .out_throttle_cmd(dut_result.throttle),
    .out_confidence_out(dut_result.confidence),
    .out_avg_left(dut_result.avg_l), .out_avg_centre(dut_result.avg_c),
    .out_avg_right(dut_result.avg_r),
    .out_rate_left(dut_result.rate_l), .out_rate_centre(dut_result.rate_c),
    .out_rate_right(dut_result.rate_r)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  // Random idling, switched off for a long window in the middle of the run.
  function automatic bit idle_now();
    if (cyc > 20000 && cyc < 40000) begin
      return 1'b0;
    end
    return $urandom_range(99) < 16;
  endfunction

  function automatic longint floor_sqrt(input longint x);
    longint root;
    longint trial;
    root = 0;
    for (int b = 18; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= x) begin
        root = trial;
      end
    end
    return root;
  endfunction

  // Fraction given in twentieths, scaled to the fixed-point format.
  function automatic longint scaled_twentieth(input int v);
    longint mag;
    mag = (v < 0) ? -v : v;
    mag = (mag * ONE + 10) / 20;
    return (v < 0) ? -mag : mag;
  endfunction

  function automatic longint rounded_quotient(input longint num, input longint den);
    longint mag;
    mag = (num < 0) ? -num : num;
    mag = (mag + den / 2) / den;
    return (num < 0) ? -mag : mag;
  endfunction

  // Append one set of readings to the driver's queue.
  task automatic queue_reading(input ranges_t r);
    pending_ranges.insert(pending_ranges.size(), r);
  endtask

  // Smooth the readings, weight the examples and form the steering transaction.
  task automatic predict_steering(input ranges_t r);
    longint x[3];
    longint pt[3];
    longint wsum[3];
    longint m, rm, c, a, sq, diff, w, total;
    steering_t exp_res;
    x[0] = r.left;
    x[1] = r.centre;
    x[2] = r.right;
    m = (shadow_mix > ONE) ? ONE : shadow_mix;
    rm = ONE - m;
    for (int i = 0; i < 3; i++) begin
      c = (m * (x[i] - last_reading[i]) + rm * rate_state[i] + HALF) >>> FRAC_BITS;
      a = (m * x[i] + rm * avg_state[i] + HALF) >>> FRAC_BITS;
      if (c > SAT_MAX) c = SAT_MAX;
      if (c < -SAT_MAX) c = -SAT_MAX;
      if (a < 0) a = 0;
      if (a > SAT_MAX) a = SAT_MAX;
      rate_state[i] = c;
      avg_state[i] = a;
      last_reading[i] = x[i];
      if (a < shadow_min) a = shadow_min;
      if (a > shadow_max) a = shadow_max;
      pt[i] = a;
      wsum[i] = 0;
    end
    total = 0;
    for (int k = 0; k < NEX; k++) begin
      sq = 0;
      for (int i = 0; i < 3; i++) begin
        diff = pt[i] - ((shadow_max * EX_QUARTER[k][i] + 2) >> 2);
        sq += diff * diff;
      end
      w = floor_sqrt(sq);
      w = (w < ONE) ? ONE - w : 0;
      for (int i = 0; i < 3; i++) begin
        wsum[i] += w * scaled_twentieth(EX_TWENTIETH[k][i]);
      end
      total += w;
    end
    if (total == 0) begin
      zero_weight_seen++;
    end
    exp_res.steer = (total != 0) ? STEERW'(rounded_quotient(wsum[0], total)) : '0;
    exp_res.throttle = (total != 0) ? QW'(rounded_quotient(wsum[1], total)) : '0;
    exp_res.confidence = (total != 0) ? QW'(rounded_quotient(wsum[2], total)) : '0;
    exp_res.avg_l = RW'(avg_state[0]);
    exp_res.avg_c = RW'(avg_state[1]);
    exp_res.avg_r = RW'(avg_state[2]);
    exp_res.rate_l = CW'(rate_state[0]);
    exp_res.rate_c = CW'(rate_state[1]);
    exp_res.rate_r = CW'(rate_state[2]);
    expected_steering.insert(expected_steering.size(), exp_res);
  endtask

  // Driver: offers queued readings, predicting each one as it is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_steering('{in_range_left, in_range_centre, in_range_right});
        readings_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_ranges.size() > 0 && !idle_now()) begin
          ranges_t nxt;
          nxt = pending_ranges.pop_front();
          in_range_left <= nxt.left;
          in_range_centre <= nxt.centre;
          in_range_right <= nxt.right;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transaction and drives the receiver stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_steering.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("ERROR: unexpected result %p", dut_result);
        end else begin
          steering_t want;
          want = expected_steering.pop_front();
          if (want.steer !== dut_result.steer || want.throttle !== dut_result.throttle ||
              want.confidence !== dut_result.confidence || want.avg_l !== dut_result.avg_l ||
              want.avg_c !== dut_result.avg_c || want.avg_r !== dut_result.avg_r ||
              want.rate_l !== dut_result.rate_l || want.rate_c !== dut_result.rate_c ||
              want.rate_r !== dut_result.rate_r) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("ERROR: result %0d mismatch", results_seen);
              $display("  expected %p", want);
              $display("  actual   %p", dut_result);
            end
          end
        end
      end
      // One long hold-off so that the block backs up into its input.
      if (!hold_done && results_seen == 400) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= idle_now();
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stall_wait <= 0;
    end else if (stall_wait >= WATCHDOG_LIMIT) begin
      $display("ERROR: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("FAIL range_fuzzy_steering");
      $finish;
    end else begin
      stall_wait <= stall_wait + 1;
    end
  end

  task automatic write_reg(input logic [CIW-1:0] idx, input logic [RW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_MIN_RANGE: shadow_min = val;
      CFG_MAX_RANGE: shadow_max = val;
      CFG_MIX:       shadow_mix = val & 16'h1FFF;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Sender pause: wait until the block has returned every expected result.
  task automatic drain();
    do @(posedge clk);
    while (pending_ranges.size() != 0 || in_valid || expected_steering.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [RW-1:0] near(input longint base, input int spread);
    longint v;
    v = base + $urandom_range(2 * spread) - spread;
    if (v < 0) v = 0;
    if (v > SAT_MAX) v = SAT_MAX;
    return RW'(v);
  endfunction

  // Random readings: mostly steady runs near an example point, plus noise.
  task automatic queue_random(input int count);
    int n;
    int k;
    int run;
    n = 0;
    while (n < count) begin
      if ($urandom_range(9) < 7) begin
        k = $urandom_range(NEX - 1);
        run = $urandom_range(10, 3);
        for (int j = 0; j < run; j++) begin
          queue_reading('{
            near((shadow_max * EX_QUARTER[k][0]) / 4, 600),
            near((shadow_max * EX_QUARTER[k][1]) / 4, 600),
            near((shadow_max * EX_QUARTER[k][2]) / 4, 600)});
        end
        n += run;
      end else if ($urandom_range(1)) begin
        queue_reading('{RW'($urandom), RW'($urandom), RW'($urandom)});
        n++;
      end else begin
        queue_reading('{near(shadow_max / 2, 8000), near(shadow_max / 2, 8000),
                        near(shadow_max / 2, 8000)});
        n++;
      end
    end
  endtask

  initial begin
    shadow_min = MIN_RANGE_RST;
    shadow_max = MAX_RANGE_RST;
    shadow_mix = MIX_RST;
    for (int i = 0; i < 3; i++) begin
      avg_state[i] = SRANGE_RST;
      rate_state[i] = 0;
      last_reading[i] = 0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, the example points, and a zero-weight point.
    queue_reading('{16'h0000, 16'h0000, 16'h0000});
    queue_reading('{16'hFFFF, 16'hFFFF, 16'hFFFF});
    queue_reading('{16'h0000, 16'hFFFF, 16'h0000});
    queue_reading('{16'hFFFF, 16'h0000, 16'hFFFF});
    queue_reading('{16'h5555, 16'hAAAA, 16'h5555});
    queue_reading('{16'hAAAA, 16'h5555, 16'hAAAA});
    for (int k = 0; k < NEX; k++) begin
      queue_reading('{RW'(2048 * EX_QUARTER[k][0]), RW'(2048 * EX_QUARTER[k][1]),
                      RW'(2048 * EX_QUARTER[k][2])});
    end
    drain();

    // Full-mix setting so that the smoothed point follows the readings.
    write_reg(CFG_MIX, 16'd4096);
    write_reg(CFG_UNUSED, 16'hFFFF);
    for (int k = 0; k < NEX; k++) begin
      queue_reading('{RW'(2048 * EX_QUARTER[k][0]), RW'(2048 * EX_QUARTER[k][1]),
                      RW'(2048 * EX_QUARTER[k][2])});
    end
    queue_reading('{16'd0, 16'd0, 16'd0});
    queue_random(300);
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_MIN_RANGE, 16'd0);
          write_reg(CFG_MAX_RANGE, 16'hFFFF);
          write_reg(CFG_MIX, 16'd0);
        end
        1: begin
          // Minimum above maximum, and a mix above one.
          write_reg(CFG_MIN_RANGE, 16'hFFFF);
          write_reg(CFG_MAX_RANGE, 16'd0);
          write_reg(CFG_MIX, 16'h1FFF);
        end
        2: begin
          write_reg(CFG_MIN_RANGE, 16'd410);
          write_reg(CFG_MAX_RANGE, 16'd8192);
          write_reg(CFG_MIX, 16'd3500);
        end
        3: begin
          write_reg(CFG_MIN_RANGE, 16'd1000);
          write_reg(CFG_MAX_RANGE, 16'd4096);
          write_reg(CFG_MIX, 16'hFFFF);
        end
        4: begin
          write_reg(CFG_MIN_RANGE, 16'd0);
          write_reg(CFG_MAX_RANGE, 16'd16384);
          write_reg(CFG_MIX, 16'd2048);
        end
        default: begin
          write_reg(CFG_MIN_RANGE, RW'($urandom_range(3000)));
          write_reg(CFG_MAX_RANGE, RW'($urandom_range(12000, 3000)));
          write_reg(CFG_MIX, 16'd4097);
        end
      endcase
      queue_random(270);
      drain();
    end

    $display("Covered %0d readings and %0d results over %0d register settings,",
             readings_sent, results_seen, NUM_PHASES + 2);
    $display("including %0d zero-weight results and a %0d-cycle output hold-off.",
             zero_weight_seen, HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("PASS range_fuzzy_steering");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAIL range_fuzzy_steering");
    end
    $finish;
  end

endmodule
